// ===== hw/rtl/hashed_timing_wheel_timer_core_assert.svh =====
// Assertion macros used by the timing wheel datapath.
`ifndef HASHED_TIMING_WHEEL_TIMER_CORE_ASSERT_SVH
`define HASHED_TIMING_WHEEL_TIMER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define HWT_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// A condition that must hold whenever a trigger is seen.
`define HWT_IMPLY(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/hwt_pkg.sv =====
// Types and constants shared by the timing wheel modules.
package hwt_pkg;

    localparam int ID_W     = 5;
    localparam int PTR_W    = ID_W + 1;
    localparam int SLOT_W   = 6;
    localparam int WHEEL_SLOTS = 1 << SLOT_W;
    localparam int MAX_TIMERS = 1 << ID_W;
    localparam int CNT_W    = ID_W + 1;
    localparam int ROUNDS_W = 24;
    localparam int DIV_W    = 25;
    localparam int DCNT_W   = 5;
    localparam int SLOTS_W  = 17;
    localparam int WAIT_W   = 17;

    localparam logic [PTR_W-1:0] PTR_NIL = {1'b1, {ID_W{1'b0}}};

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_ADJUST = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_CLEAR,
        DP_LOAD_ID,
        DP_ENT_RD,
        DP_UNLINK,
        DP_DIV_START,
        DP_SC_HEAD,
        DP_SC_LINK,
        DP_SC_BACK,
        DP_TK_INIT,
        DP_TK_STEP,
        DP_TK_END,
        DP_HEAD_RD,
        DP_HEAD_USE,
        DP_DEC,
        DP_EXPIRE,
        DP_WAIT_RES
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       present_id;
        logic       cnt_zero;
        logic       div_done;
        logic       slots_zero;
        logic       cur_nil;
        logic       rounds_zero;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/hwt_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module hwt_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [hwt_pkg::DIV_W-1:0]   dividend,
    input  logic [15:0]                 divisor,
    output logic                        done,
    output logic [hwt_pkg::DIV_W-1:0]   quotient,
    output logic [15:0]                 remainder
);

    logic [15:0]                 acc_reg, acc_next;
    logic [hwt_pkg::DIV_W-1:0]   quo_reg, quo_next;
    logic [15:0]                 dvs_reg;
    logic [hwt_pkg::DCNT_W-1:0]  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [16:0]                 trial;
    logic [16:0]                 diff;
    logic                        fits;

    always_comb begin
        trial    = {acc_reg, quo_reg[hwt_pkg::DIV_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        acc_next = fits ? diff[15:0] : trial[15:0];
        quo_next = {quo_reg[hwt_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == hwt_pkg::DCNT_W'(hwt_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = acc_reg;

endmodule

// ===== hw/rtl/hwt_dp.sv =====
// Datapath of the timing wheel: slot heads, timer entries, divider and result register.
`include "hashed_timing_wheel_timer_core_assert.svh"

module hwt_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hwt_pkg::dp_cmd_t      cmd,
    output hwt_pkg::dp_status_t   status,
    input  logic [47:0]           s_tdata,
    input  logic [2:0]            s_tuser,
    input  logic                  cfg_valid,
    input  logic [15:0]           cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic [0:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int IW = hwt_pkg::ID_W;
    localparam int PW = hwt_pkg::PTR_W;
    localparam int SW = hwt_pkg::SLOT_W;

    logic [IW-1:0]                 head_mem [hwt_pkg::WHEEL_SLOTS];
    logic [PW-1:0]                 next_mem [hwt_pkg::MAX_TIMERS];
    logic [PW-1:0]                 prev_mem [hwt_pkg::MAX_TIMERS];
    logic [SW-1:0]                 slot_mem [hwt_pkg::MAX_TIMERS];
    logic [hwt_pkg::ROUNDS_W-1:0]  rounds_mem [hwt_pkg::MAX_TIMERS];

    logic [hwt_pkg::WHEEL_SLOTS-1:0] head_vld_reg;
    logic [hwt_pkg::MAX_TIMERS-1:0] present_reg;
    logic [hwt_pkg::CNT_W-1:0]      cnt_reg;
    logic [SW-1:0]                  pos_reg;
    logic [15:0]                    rem_reg;
    logic [15:0]                    period_reg;

    logic [2:0]                     op_reg;
    logic [IW-1:0]                  id_reg;
    logic [23:0]                    timeout_reg;
    logic [15:0]                    elapsed_reg;
    logic [PW-1:0]                  cur_reg;
    logic [SW-1:0]                  sl_reg;
    logic [hwt_pkg::ROUNDS_W-1:0]   rounds_reg;
    logic [hwt_pkg::SLOTS_W-1:0]    slots_left_reg;
    logic [SW-1:0]                  vis_reg;
    logic [SW-1:0]                  adv_reg;

    logic [IW-1:0]                  head_rd_reg;
    logic                           hvld_rd_reg;
    logic [PW-1:0]                  next_rd_reg;
    logic [PW-1:0]                  prev_rd_reg;
    logic [SW-1:0]                  slot_rd_reg;
    logic [hwt_pkg::ROUNDS_W-1:0]   rounds_rd_reg;

    logic                           m_valid_reg;
    logic [23:0]                    m_data_reg;
    logic                           m_user_reg;
    logic                           m_last_reg;

    logic [15:0]                    period_eff;
    logic [hwt_pkg::DIV_W-1:0]      dividend;
    logic                           div_done;
    logic [hwt_pkg::DIV_W-1:0]      div_q;
    logic [15:0]                    div_r;
    logic [hwt_pkg::DIV_W-1:0]      n_val;
    logic [hwt_pkg::DIV_W-1:0]      n_less;
    logic [hwt_pkg::ROUNDS_W-1:0]   rounds_new;
    logic [SW-1:0]                  sl_new;
    logic                           unlink;
    logic                           out_free;
    logic                           out_load;
    logic [hwt_pkg::WAIT_W-1:0]     wait_val;
    logic                           walk_rd;
    logic                           walk_ok;

    logic                           head_we;
    logic [SW-1:0]                  head_wa;
    logic [SW-1:0]                  head_ra;
    logic                           next_we;
    logic [IW-1:0]                  next_wa;
    logic [PW-1:0]                  next_wd;
    logic                           prev_we;
    logic [IW-1:0]                  prev_wa;
    logic [PW-1:0]                  prev_wd;
    logic                           rounds_we;
    logic [IW-1:0]                  rounds_wa;
    logic [hwt_pkg::ROUNDS_W-1:0]   rounds_wd;

    always_comb begin
        period_eff = (period_reg == 16'd0) ? 16'd1 : period_reg;
        if (op_reg == hwt_pkg::OP_TICK) begin
            dividend = {9'd0, elapsed_reg} + {9'd0, rem_reg};
        end else begin
            dividend = {1'b0, timeout_reg} + {9'd0, elapsed_reg} + {9'd0, rem_reg};
        end
        n_val      = div_q + {{(hwt_pkg::DIV_W-1){1'b0}}, (div_r != 16'd0)};
        n_less     = n_val - 1'b1;
        rounds_new = (n_val == '0) ? '0
                   : hwt_pkg::ROUNDS_W'(n_less >> SW);
        sl_new     = pos_reg + n_val[SW-1:0];
        unlink     = (cmd == hwt_pkg::DP_UNLINK) || (cmd == hwt_pkg::DP_EXPIRE);
        out_free   = !m_valid_reg || m_tready;
        out_load   = (cmd == hwt_pkg::DP_EXPIRE) || (cmd == hwt_pkg::DP_WAIT_RES);
        wait_val   = (cnt_reg == '0) ? '1 : ({1'b0, period_eff} - {1'b0, rem_reg});
        head_ra    = (cmd == hwt_pkg::DP_SC_HEAD) ? sl_new : vis_reg;
        walk_rd    = (cmd == hwt_pkg::DP_ENT_RD) && !cur_reg[IW];
        walk_ok    = present_reg[cur_reg[IW-1:0]];
    end

    always_comb begin
        head_we   = 1'b0;
        head_wa   = sl_reg;
        next_we   = 1'b0;
        next_wa   = id_reg;
        next_wd   = hwt_pkg::PTR_NIL;
        prev_we   = 1'b0;
        prev_wa   = id_reg;
        prev_wd   = hwt_pkg::PTR_NIL;
        rounds_we = 1'b0;
        rounds_wa = id_reg;
        rounds_wd = rounds_reg;
        if (cmd == hwt_pkg::DP_SC_LINK) begin
            head_we   = 1'b1;
            next_we   = 1'b1;
            next_wd   = hvld_rd_reg ? {1'b0, head_rd_reg} : hwt_pkg::PTR_NIL;
            prev_we   = 1'b1;
            rounds_we = 1'b1;
        end
        if (cmd == hwt_pkg::DP_SC_BACK) begin
            prev_we = hvld_rd_reg;
            prev_wa = head_rd_reg;
            prev_wd = {1'b0, id_reg};
        end
        if (unlink) begin
            head_wa = slot_rd_reg;
            head_we = prev_rd_reg[IW] && !next_rd_reg[IW];
            next_we = !prev_rd_reg[IW];
            next_wa = prev_rd_reg[IW-1:0];
            next_wd = next_rd_reg;
            prev_we = !next_rd_reg[IW];
            prev_wa = next_rd_reg[IW-1:0];
            prev_wd = prev_rd_reg;
        end
        if (cmd == hwt_pkg::DP_DEC) begin
            rounds_we = 1'b1;
            rounds_wa = cur_reg[IW-1:0];
            rounds_wd = rounds_rd_reg - 1'b1;
        end
    end

    hwt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd == hwt_pkg::DP_DIV_START),
        .dividend  (dividend),
        .divisor   (period_eff),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_vld_reg <= '0;
            present_reg  <= '0;
            cnt_reg      <= '0;
            pos_reg      <= '0;
            rem_reg      <= '0;
            period_reg   <= 16'd100;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                period_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd)
                hwt_pkg::DP_CLEAR: begin
                    head_vld_reg <= '0;
                    present_reg  <= '0;
                    cnt_reg      <= '0;
                end
                hwt_pkg::DP_SC_LINK: begin
                    head_vld_reg[sl_reg] <= 1'b1;
                    present_reg[id_reg]  <= 1'b1;
                    cnt_reg              <= cnt_reg + 1'b1;
                end
                hwt_pkg::DP_UNLINK, hwt_pkg::DP_EXPIRE: begin
                    if (prev_rd_reg[IW] && next_rd_reg[IW]) begin
                        head_vld_reg[slot_rd_reg] <= 1'b0;
                    end
                    present_reg[cur_reg[IW-1:0]] <= 1'b0;
                    cnt_reg <= cnt_reg - 1'b1;
                end
                hwt_pkg::DP_TK_INIT: begin
                    rem_reg <= div_r;
                end
                hwt_pkg::DP_TK_END: begin
                    pos_reg <= pos_reg + adv_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            hwt_pkg::DP_CAPTURE: begin
                op_reg      <= s_tuser;
                id_reg      <= s_tdata[4:0];
                timeout_reg <= s_tdata[28:5];
                elapsed_reg <= s_tdata[44:29];
            end
            hwt_pkg::DP_LOAD_ID: begin
                cur_reg <= {1'b0, id_reg};
            end
            hwt_pkg::DP_SC_HEAD: begin
                sl_reg     <= sl_new;
                rounds_reg <= rounds_new;
            end
            hwt_pkg::DP_TK_INIT: begin
                slots_left_reg <= div_q[hwt_pkg::SLOTS_W-1:0];
                adv_reg        <= div_q[SW-1:0];
                vis_reg        <= pos_reg;
            end
            hwt_pkg::DP_TK_STEP: begin
                slots_left_reg <= slots_left_reg - 1'b1;
                vis_reg        <= vis_reg + 1'b1;
            end
            hwt_pkg::DP_HEAD_USE: begin
                cur_reg <= hvld_rd_reg ? {1'b0, head_rd_reg} : hwt_pkg::PTR_NIL;
            end
            hwt_pkg::DP_DEC, hwt_pkg::DP_EXPIRE: begin
                cur_reg <= next_rd_reg;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            if (cmd == hwt_pkg::DP_EXPIRE) begin
                m_data_reg <= {2'b00, {hwt_pkg::WAIT_W{1'b0}}, cur_reg[IW-1:0]};
                m_user_reg <= 1'b1;
                m_last_reg <= 1'b0;
            end else begin
                m_data_reg <= {2'b00, wait_val, {IW{1'b0}}};
                m_user_reg <= 1'b0;
                m_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((cmd == hwt_pkg::DP_SC_HEAD) || (cmd == hwt_pkg::DP_HEAD_RD)) begin
            head_rd_reg <= head_mem[head_ra];
            hvld_rd_reg <= head_vld_reg[head_ra];
        end
        if (head_we) begin
            head_mem[head_wa] <= (cmd == hwt_pkg::DP_SC_LINK) ? id_reg
                                                                : next_rd_reg[IW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd == hwt_pkg::DP_ENT_RD) begin
            next_rd_reg   <= next_mem[cur_reg[IW-1:0]];
            prev_rd_reg   <= prev_mem[cur_reg[IW-1:0]];
            slot_rd_reg   <= slot_mem[cur_reg[IW-1:0]];
            rounds_rd_reg <= rounds_mem[cur_reg[IW-1:0]];
        end
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (rounds_we) begin
            rounds_mem[rounds_wa] <= rounds_wd;
        end
        if (cmd == hwt_pkg::DP_SC_LINK) begin
            slot_mem[id_reg] <= sl_reg;
        end
    end

    always_comb begin
        status.op          = op_reg;
        status.present_id  = present_reg[id_reg];
        status.cnt_zero    = (cnt_reg == '0);
        status.div_done    = div_done;
        status.slots_zero  = (slots_left_reg == '0);
        status.cur_nil     = cur_reg[IW];
        status.rounds_zero = (rounds_rd_reg == '0);
        status.out_free    = out_free;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `HWT_CHECK(a_count_matches, $countones(present_reg) == int'(cnt_reg), "count out of step")
    `HWT_IMPLY(a_walk_present, walk_rd, walk_ok, "list walk reached an absent timer")
    `HWT_IMPLY(a_load_free, out_load, out_free, "result loaded over an untaken beat")

endmodule

// ===== hw/rtl/hwt_ctrl.sv =====
// Controller state machine that sequences the timing wheel datapath.
module hwt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  hwt_pkg::dp_status_t   status,
    output hwt_pkg::dp_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UL_RD,
        ST_UL_WR,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SC_HEAD,
        ST_SC_LINK,
        ST_SC_BACK,
        ST_TK_INIT,
        ST_TK_SLOT,
        ST_TK_HRD,
        ST_TK_HUSE,
        ST_TK_ENT,
        ST_TK_EXEC,
        ST_WAIT_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   resched;

    always_comb begin
        resched    = (status.op == hwt_pkg::OP_ADD) || (status.op == hwt_pkg::OP_ADJUST);
        state_next = state_reg;
        cmd        = hwt_pkg::DP_NOP;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd        = hwt_pkg::DP_CAPTURE;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.op)
                    hwt_pkg::OP_ADD: begin
                        cmd        = hwt_pkg::DP_LOAD_ID;
                        state_next = status.present_id ? ST_UL_RD : ST_DIV_GO;
                    end
                    hwt_pkg::OP_ADJUST, hwt_pkg::OP_DELETE: begin
                        cmd        = hwt_pkg::DP_LOAD_ID;
                        state_next = status.present_id ? ST_UL_RD : ST_IDLE;
                    end
                    hwt_pkg::OP_TICK: begin
                        state_next = status.cnt_zero ? ST_WAIT_OUT : ST_DIV_GO;
                    end
                    hwt_pkg::OP_CLEAR: begin
                        cmd        = hwt_pkg::DP_CLEAR;
                        state_next = ST_IDLE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_UL_RD: begin
                cmd        = hwt_pkg::DP_ENT_RD;
                state_next = ST_UL_WR;
            end
            ST_UL_WR: begin
                cmd        = hwt_pkg::DP_UNLINK;
                state_next = resched ? ST_DIV_GO : ST_IDLE;
            end
            ST_DIV_GO: begin
                cmd        = hwt_pkg::DP_DIV_START;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = (status.op == hwt_pkg::OP_TICK) ? ST_TK_INIT : ST_SC_HEAD;
                end
            end
            ST_SC_HEAD: begin
                cmd        = hwt_pkg::DP_SC_HEAD;
                state_next = ST_SC_LINK;
            end
            ST_SC_LINK: begin
                cmd        = hwt_pkg::DP_SC_LINK;
                state_next = ST_SC_BACK;
            end
            ST_SC_BACK: begin
                cmd        = hwt_pkg::DP_SC_BACK;
                state_next = ST_IDLE;
            end
            ST_TK_INIT: begin
                cmd        = hwt_pkg::DP_TK_INIT;
                state_next = ST_TK_SLOT;
            end
            ST_TK_SLOT: begin
                if (status.slots_zero || status.cnt_zero) begin
                    cmd        = hwt_pkg::DP_TK_END;
                    state_next = ST_WAIT_OUT;
                end else begin
                    cmd        = hwt_pkg::DP_TK_STEP;
                    state_next = ST_TK_HRD;
                end
            end
            ST_TK_HRD: begin
                cmd        = hwt_pkg::DP_HEAD_RD;
                state_next = ST_TK_HUSE;
            end
            ST_TK_HUSE: begin
                cmd        = hwt_pkg::DP_HEAD_USE;
                state_next = ST_TK_ENT;
            end
            ST_TK_ENT: begin
                if (status.cur_nil) begin
                    state_next = ST_TK_SLOT;
                end else begin
                    cmd        = hwt_pkg::DP_ENT_RD;
                    state_next = ST_TK_EXEC;
                end
            end
            ST_TK_EXEC: begin
                if (!status.rounds_zero) begin
                    cmd        = hwt_pkg::DP_DEC;
                    state_next = ST_TK_ENT;
                end else if (status.out_free) begin
                    cmd        = hwt_pkg::DP_EXPIRE;
                    state_next = ST_TK_ENT;
                end
            end
            ST_WAIT_OUT: begin
                if (status.out_free) begin
                    cmd        = hwt_pkg::DP_WAIT_RES;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ===== hw/rtl/hashed_timing_wheel_timer_core.sv =====
// Hashed timing wheel of 32 one-shot timers on 64 slots, with a slot period
// register. Commands come in one beat at a time and the next beat is taken
// only once the previous command has finished. An add or adjust first unlinks
// the timer when it is already held, then waits on the shared restoring divider
// that forms the slot count; an adjust of an absent timer does nothing. A
// delete unlinks the timer if it is held, and a clear empties the wheel. A tick
// with no timers held skips the division. Otherwise a tick waits on its
// division, then walks every wheel slot it advances over and every timer found
// in those slots, and may wait for the downstream side to take a result beat.
// Each expired timer gives one beat with tuser set, and every tick ends with
// one beat carrying tlast and the wait time.
module hashed_timing_wheel_timer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // timer_id, timeout_ms, elapsed_ms
    input  logic [2:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // expired_id, wait_ms
    output logic [0:0]  m_tuser,   // expired_valid
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    hwt_pkg::dp_cmd_t    cmd;
    hwt_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    hwt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hwt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
